// ===== sv/assert_macros.svh =====
// Assertion helper macros shared by the winding-number RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ===== sv/piw_pkg.sv =====
// Shared types, constants and edge-setup function for the winding-number block.
// No dependencies; used by every module of the block.
package piw_pkg;

  localparam int COORD_W      = 24;
  localparam int MAX_VERTICES = 1024;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int WIND_W       = 11;
  localparam int WIND_MAX     = 1023;
  localparam int WIND_MIN     = -1024;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [WIND_W-1:0]  wind_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  // Operands of one edge test: cross = dx*dqy - dqx*dy
  typedef struct packed {
    diff_t dx;
    diff_t dqy;
    diff_t dqx;
    diff_t dy;
    logic  up;    // upward crossing candidate, needs q strictly left
    logic  down;  // downward crossing candidate, needs q strictly right
  } edge_t;

  // One classified vertex beat handed from front to back
  typedef struct packed {
    edge_t e0;    // edge previous -> current
    edge_t e1;    // closing edge, only on the last vertex
    logic  last;
    logic  ovf;
  } item_t;

  // Result beat
  typedef struct packed {
    logic  ovf;
    wind_t wind;
    logic  in_poly;
  } result_t;

  function automatic edge_t make_edge(point_t a, point_t b, point_t q, logic en);
    edge_t e;
    e.dx   = DIFF_W'(b.x) - DIFF_W'(a.x);
    e.dqy  = DIFF_W'(q.y) - DIFF_W'(a.y);
    e.dqx  = DIFF_W'(q.x) - DIFF_W'(a.x);
    e.dy   = DIFF_W'(b.y) - DIFF_W'(a.y);
    e.up   = en && (a.y <= q.y) && (b.y > q.y);
    e.down = en && (a.y > q.y) && (b.y <= q.y);
    return e;
  endfunction

endpackage

// ===== sv/piw_front.sv =====
// Front end: accepts vertex beats, tracks polygon state, classifies edges.
// Depends on piw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  piw_pkg::point_t   vertex_i,
  input  piw_pkg::point_t   query_i,
  input  logic              last_i,
  input  logic              full_i,
  output logic              push_o,
  output piw_pkg::item_t    item_o
);

  piw_pkg::point_t               first_q, first_d;
  piw_pkg::point_t               prev_q, prev_d;
  piw_pkg::point_t               query_q, query_d;
  logic [piw_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;

  logic            in_acc;
  logic            start;
  logic            sat;
  logic            edge_en;
  piw_pkg::point_t q_use;

  assign s_tready_o = !full_i;
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign push_o     = in_acc;

  // Classify the beat and build both edge records
  always_comb begin
    start   = (cnt_q == '0);
    sat     = (cnt_q >= piw_pkg::CNT_W'(piw_pkg::MAX_VERTICES));
    edge_en = !start && !sat;
    q_use   = start ? query_i : query_q;
    prev_d  = (start || edge_en) ? vertex_i : prev_q;
    first_d = start ? vertex_i : first_q;
    query_d = q_use;
    ovf_d   = ovf_q || (!start && sat);

    item_o.e0   = piw_pkg::make_edge(prev_q, vertex_i, q_use, edge_en);
    item_o.e1   = piw_pkg::make_edge(prev_d, first_d, q_use, last_i);
    item_o.last = last_i;
    item_o.ovf  = ovf_d;

    if (last_i) begin
      cnt_d = '0;
    end else if (start) begin
      cnt_d = piw_pkg::CNT_W'(1);
    end else if (edge_en) begin
      cnt_d = cnt_q + piw_pkg::CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // Polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      prev_q  <= '0;
      query_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      first_q <= first_d;
      prev_q  <= prev_d;
      query_q <= query_d;
      cnt_q   <= cnt_d;
      ovf_q   <= last_i ? 1'b0 : ovf_d;
    end
  end

  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= piw_pkg::CNT_W'(piw_pkg::MAX_VERTICES))
  `ASSERT_NEXT(a_last_restart, in_acc && last_i, cnt_q == '0 && !ovf_q)
  `ASSERT_IMPL(a_ovf_saturated, ovf_q, cnt_q == piw_pkg::CNT_W'(piw_pkg::MAX_VERTICES))

endmodule

// ===== sv/piw_queue.sv =====
// Short FIFO of classified vertex items between front and back.
// Depends on piw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  piw_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output piw_pkg::item_t  item_o
);

  piw_pkg::item_t              mem_q [piw_pkg::QUEUE_DEPTH];
  logic [piw_pkg::QPTR_W-1:0]  wr_q, wr_d;
  logic [piw_pkg::QPTR_W-1:0]  rd_q, rd_d;
  logic [piw_pkg::QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == piw_pkg::QCNT_W'(piw_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  // Pointer and fill-count update
  always_comb begin
    wr_d  = push_i ? wr_q + piw_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + piw_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + piw_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - piw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `ASSERT_IMPL(a_no_push_full, push_i, !full_o)
  `ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o)
  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= piw_pkg::QCNT_W'(piw_pkg::QUEUE_DEPTH))

endmodule

// ===== sv/piw_back.sv =====
// Back end: cross-product multiply stage, winding accumulation, result register.
// Depends on piw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  piw_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output piw_pkg::result_t  result_o
);

  typedef struct packed {
    piw_pkg::prod_t p0a;
    piw_pkg::prod_t p0b;
    piw_pkg::prod_t p1a;
    piw_pkg::prod_t p1b;
    logic           up0;
    logic           down0;
    logic           up1;
    logic           down1;
    logic           last;
    logic           ovf;
  } mult_t;

  mult_t             mul_q, mul_d;
  logic              mv_q;
  logic              m_adv;
  logic              m_ready;
  piw_pkg::wind_t    acc_q, acc_d;
  piw_pkg::wind_t    w1, w2;
  piw_pkg::result_t  out_q, out_d;
  logic              ov_q;

  // Winding change of one edge from the sign of its cross product
  function automatic logic signed [1:0] edge_delta(piw_pkg::prod_t pa, piw_pkg::prod_t pb,
                                                   logic up, logic down);
    logic signed [piw_pkg::PROD_W:0] diff;
    logic                            pos;
    logic                            neg;
    diff = (piw_pkg::PROD_W+1)'(pa) - (piw_pkg::PROD_W+1)'(pb);
    neg  = diff[piw_pkg::PROD_W];
    pos  = !neg && (diff != '0);
    if (up && pos) begin
      return 2'sb01;
    end else if (down && neg) begin
      return 2'sb11;
    end else begin
      return 2'sb00;
    end
  endfunction

  // Saturating add into the winding count
  function automatic piw_pkg::wind_t wind_add(piw_pkg::wind_t w, logic signed [1:0] d);
    logic signed [piw_pkg::WIND_W:0] s;
    s = (piw_pkg::WIND_W+1)'(w) + (piw_pkg::WIND_W+1)'(d);
    if (s > (piw_pkg::WIND_W+1)'(piw_pkg::WIND_MAX)) begin
      s = (piw_pkg::WIND_W+1)'(piw_pkg::WIND_MAX);
    end else if (s < (piw_pkg::WIND_W+1)'(piw_pkg::WIND_MIN)) begin
      s = (piw_pkg::WIND_W+1)'(piw_pkg::WIND_MIN);
    end
    return piw_pkg::WIND_W'(s);
  endfunction

  // Stage handshake: a last item needs a free result slot
  assign m_adv   = mv_q && (!mul_q.last || !ov_q || m_tready_i);
  assign m_ready = !mv_q || m_adv;
  assign pop_o   = !empty_i && m_ready;

  // Multiply stage operands
  always_comb begin
    mul_d.p0a   = piw_pkg::PROD_W'(item_i.e0.dx)  * piw_pkg::PROD_W'(item_i.e0.dqy);
    mul_d.p0b   = piw_pkg::PROD_W'(item_i.e0.dqx) * piw_pkg::PROD_W'(item_i.e0.dy);
    mul_d.p1a   = piw_pkg::PROD_W'(item_i.e1.dx)  * piw_pkg::PROD_W'(item_i.e1.dqy);
    mul_d.p1b   = piw_pkg::PROD_W'(item_i.e1.dqx) * piw_pkg::PROD_W'(item_i.e1.dy);
    mul_d.up0   = item_i.e0.up;
    mul_d.down0 = item_i.e0.down;
    mul_d.up1   = item_i.e1.up;
    mul_d.down1 = item_i.e1.down;
    mul_d.last  = item_i.last;
    mul_d.ovf   = item_i.ovf;
  end

  // Accumulate: running edge first, closing edge second
  always_comb begin
    w1            = wind_add(acc_q, edge_delta(mul_q.p0a, mul_q.p0b, mul_q.up0, mul_q.down0));
    w2            = wind_add(w1, edge_delta(mul_q.p1a, mul_q.p1b, mul_q.up1, mul_q.down1));
    acc_d         = mul_q.last ? '0 : w2;
    out_d.ovf     = mul_q.ovf;
    out_d.wind    = w2;
    out_d.in_poly = (w2 != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q  <= 1'b0;
      acc_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (m_ready) begin
        mv_q <= pop_o;
      end
      if (m_adv) begin
        acc_q <= acc_d;
      end
      if (m_adv && mul_q.last) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mul_q <= mul_d;
    end
    if (m_adv && mul_q.last) begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = ov_q;
  assign result_o   = out_q;

  `ASSERT_NEXT(a_acc_clear, m_adv && mul_q.last, acc_q == '0 && ov_q)
  `ASSERT_IMPL(a_inside_match, ov_q, out_q.in_poly == (out_q.wind != '0))
  `ASSERT_IMPL(a_pop_space, pop_o, !mv_q || m_adv)

endmodule

// ===== sv/point_in_polygon_winding.sv =====
// Point-in-polygon test by winding number over a stream of polygon vertices.
// One vertex beat is taken per cycle while the queue has room; the first vertex
// of a polygon also latches the query point, and a beat with tlast closes the
// polygon and yields one result beat. The rate is set by two parallel edge lanes
// (running edge and closing edge), each a pair of 25x25 signed multipliers
// followed by a compare and a saturating counter update. A result passes through
// the queue, the multiply stage register and the result register; a four-entry
// queue between the classifying front end and the arithmetic back end absorbs
// output stalls. Polygons beyond 1024 vertices are truncated and flagged.
// Depends on piw_pkg, piw_front, piw_queue and piw_back.

module point_in_polygon_winding (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] vertex_x, [47:24] vertex_y, [71:48] query_x, [95:72] query_y
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] inside_res, [11:1] winding_number, [12] count_overflow, [15:13] zero
  output logic [15:0] m_axis_tdata
);

  piw_pkg::point_t   vertex;
  piw_pkg::point_t   query;
  piw_pkg::item_t    item_in;
  piw_pkg::item_t    item_out;
  piw_pkg::result_t  result;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  // Unpack input beat
  assign vertex.x = piw_pkg::coord_t'(s_axis_tdata[23:0]);
  assign vertex.y = piw_pkg::coord_t'(s_axis_tdata[47:24]);
  assign query.x  = piw_pkg::coord_t'(s_axis_tdata[71:48]);
  assign query.y  = piw_pkg::coord_t'(s_axis_tdata[95:72]);

  piw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .vertex_i   (vertex),
    .query_i    (query),
    .last_i     (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .item_o     (item_in)
  );

  piw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (item_out)
  );

  piw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (item_out),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .result_o   (result)
  );

  // Pack result beat
  assign m_axis_tdata = {3'b000, result.ovf, result.wind, result.in_poly};

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for point_in_polygon_winding: streams polygon vertex beats
// and predicts the winding result of each polygon, checking every result beat.
// Depends on piw_pkg and the point_in_polygon_winding RTL.
module testbench;
  import piw_pkg::*;

  localparam int      CLK_HALF   = 5;
  localparam int      RUN_LIMIT  = 400000;
  localparam int      RANDOM_LEN = 650;
  localparam int      DRAIN_WAIT = 20;
  localparam longint  CMIN       = -(longint'(1) << (COORD_W - 1));
  localparam longint  CMAX       = (longint'(1) << (COORD_W - 1)) - 1;
  localparam real     TWO_PI     = 6.283185307179586;

  // Winding predictor plus queue of results still owed by the block
  class winding_tracker;
    point_t    first_pt, prev_pt, query_pt;
    int        wind;
    int        vcount;
    bit        ovf;
    result_t   owed_results[$];
    int        mismatches;

    // Exact crossing rule for edge a->b seen from q
    function int crossing_delta(point_t a, point_t b, point_t q);
      longint dx, dy, dqx, dqy, xprod;
      dx    = longint'(b.x) - longint'(a.x);
      dy    = longint'(b.y) - longint'(a.y);
      dqx   = longint'(q.x) - longint'(a.x);
      dqy   = longint'(q.y) - longint'(a.y);
      xprod = dx * dqy - dqx * dy;
      if (a.y <= q.y) begin
        if (b.y > q.y && xprod > 0) return 1;
      end else begin
        if (b.y <= q.y && xprod < 0) return -1;
      end
      return 0;
    endfunction

    function void add_crossing(point_t a, point_t b);
      wind = wind + crossing_delta(a, b, query_pt);
      if (wind > WIND_MAX) wind = WIND_MAX;
      if (wind < WIND_MIN) wind = WIND_MIN;
    endfunction

    // Called for every accepted vertex beat
    function void take_vertex(point_t v, point_t q, bit last);
      result_t r;
      if (vcount == 0) begin
        query_pt = q;
        first_pt = v;
        prev_pt  = v;
        vcount   = 1;
      end else if (vcount >= MAX_VERTICES) begin
        ovf = 1'b1;
      end else begin
        add_crossing(prev_pt, v);
        prev_pt = v;
        vcount++;
      end
      if (last) begin
        add_crossing(prev_pt, first_pt);
        r.in_poly = (wind != 0);
        r.wind    = wind_t'(wind);
        r.ovf     = ovf;
        owed_results = {owed_results, r};
        wind   = 0;
        vcount = 0;
        ovf    = 1'b0;
      end
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Called for every accepted result beat
    function void check_result(logic [15:0] beat);
      result_t got, want;
      got = beat[12:0];
      if (owed_results.size() == 0) begin
        flag("unexpected result beat, winding", 0, $signed(got.wind));
        return;
      end
      want = owed_results.pop_front();
      if (got.in_poly !== want.in_poly) flag("inside_res", want.in_poly, got.in_poly);
      if (got.wind !== want.wind)
        flag("winding_number", $signed(want.wind), $signed(got.wind));
      if (got.ovf !== want.ovf) flag("count_overflow", want.ovf, got.ovf);
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  winding_tracker tracker;
  int send_idle;
  int recv_stall;
  int cycles;
  int sent_items;

  point_in_polygon_winding dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check accepted beats, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic point_t pt(longint x, longint y);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    return p;
  endfunction

  function automatic longint clip(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic point_t any_point();
    return pt(longint'($signed(coord_t'($urandom))), longint'($signed(coord_t'($urandom))));
  endfunction

  // Idle pattern per phase: none, sender, receiver, both
  task automatic set_phase(int ph);
    case (ph)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 80; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 80; end
      default: begin send_idle = 19; recv_stall = 19; end
    endcase
  endtask

  // One vertex beat; returns after the accepting edge
  task automatic send_vertex(point_t v, point_t q, bit last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.y, q.x, v.y, v.x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_vertex(v, q, last);
    sent_items++;
  endtask

  // Query rides on the first beat; later beats carry noise in the query fields
  task automatic send_polygon(point_t pts[$], point_t q);
    foreach (pts[i])
      send_vertex(pts[i], (i == 0) ? q : any_point(), i == pts.size() - 1);
  endtask

  // Small-grid polygon: many collinear, on-edge and on-vertex queries
  task automatic grid_polygon(int n, bit q_on_vertex);
    point_t pts[$];
    longint bx, by, s;
    bx = longint'($urandom_range(0, 16000000)) - 8000000;
    by = longint'($urandom_range(0, 16000000)) - 8000000;
    s  = longint'(1) << $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      pts = {pts, pt(bx + s * ($urandom_range(0, 6) - 3),
                     by + s * ($urandom_range(0, 6) - 3))};
    if (q_on_vertex)
      send_polygon(pts, pts[$urandom_range(0, n - 1)]);
    else
      send_polygon(pts, pt(bx + (s / 2) * ($urandom_range(0, 12) - 6),
                           by + (s / 2) * ($urandom_range(0, 12) - 6)));
  endtask

  // Star polygon circling a center one or more times, either direction
  task automatic ring_polygon();
    point_t pts[$];
    point_t q;
    longint r, cx, cy;
    int turns, n;
    real ang, a0;
    q     = pt(longint'($urandom_range(0, 8000000)) - 4000000,
               longint'($urandom_range(0, 8000000)) - 4000000);
    r     = $urandom_range(4, 1 << 22);
    turns = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
    n     = turns * $urandom_range(3, 8) + $urandom_range(0, 2);
    cx    = longint'(q.x)
          + ($urandom_range(3) == 0 ? r * (longint'($urandom_range(0, 4)) - 2) : 0)
          + longint'($urandom_range(0, 4)) - 2;
    cy    = longint'(q.y) + longint'($urandom_range(0, 4)) - 2;
    a0    = $urandom_range(0, 999) / 1000.0;
    for (int i = 0; i < n; i++) begin
      ang = a0 + TWO_PI * turns * i / n;
      if ($urandom_range(1)) ang = -ang;
      pts = {pts, pt(clip(cx + $rtoi(r * $cos(ang))), clip(cy + $rtoi(r * $sin(ang))))};
    end
    send_polygon(pts, q);
  endtask

  // Polygon on the coordinate extremes
  task automatic corner_polygon(int n);
    longint picks[7] = '{CMIN, CMAX, 0, -1, 1, CMIN + 1, CMAX - 1};
    point_t pts[$];
    for (int i = 0; i < n; i++)
      pts = {pts, pt(picks[$urandom_range(0, 6)], picks[$urandom_range(0, 6)])};
    send_polygon(pts, pt(picks[$urandom_range(0, 6)], picks[$urandom_range(0, 6)]));
  endtask

  task automatic wide_polygon(int n);
    point_t pts[$];
    for (int i = 0; i < n; i++) pts = {pts, any_point()};
    send_polygon(pts, any_point());
  endtask

  // Main sequence
  initial begin
    int kind, budget;
    bit limit_done;
    point_t sq[$];
    tracker = new();
    set_phase(0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single vertex, both directions, boundary queries, extremes
    send_polygon('{pt(0, 0)}, pt(0, 0));
    sq = '{pt(0, 0), pt(4, 0), pt(4, 4), pt(0, 4)};
    send_polygon(sq, pt(2, 2));
    send_polygon('{pt(0, 0), pt(0, 4), pt(4, 4), pt(4, 0)}, pt(1, 1));
    send_polygon(sq, pt(0, 2));
    send_polygon(sq, pt(4, 2));
    send_polygon('{pt(CMIN, CMIN), pt(CMAX, CMIN), pt(CMAX, CMAX)}, pt(CMAX, 0));
    send_polygon('{pt(CMIN, CMIN), pt(CMAX, CMIN), pt(CMAX, CMAX)}, pt(CMIN, CMIN));
    send_polygon('{pt(CMAX, CMAX), pt(CMIN, CMAX), pt(CMIN, CMIN)}, pt(-1, 0));

    // Random polygons, cycling through the idle phases
    limit_done = 1'b0;
    budget     = RANDOM_LEN;
    while (sent_items < budget) begin
      set_phase((sent_items / 60) % 4);
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: grid_polygon($urandom_range(3, 10), 1'b0);
        3:       grid_polygon($urandom_range(3, 8), 1'b1);
        4, 5:    ring_polygon();
        6:       wide_polygon($urandom_range(3, 8));
        7:       corner_polygon($urandom_range(1, 6));
        8:       grid_polygon($urandom_range(1, 2), 1'b0);
        default: wide_polygon($urandom_range(1, 12));
      endcase
      // Vertex-count limit: one polygon past it, truncated and flagged
      if (!limit_done && sent_items >= RANDOM_LEN / 2) begin
        grid_polygon(MAX_VERTICES + 3, 1'b0);
        limit_done = 1'b1;
        budget     = RANDOM_LEN + MAX_VERTICES + 3;
      end
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    set_phase(0);
    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
